// ===== rtl/svg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere vertex generator package
// Shared constants, register addresses and the quarter sine coefficients and Horner step.
// ----------------------------------------------------------------------------
package svg_pkg;

   localparam int DEF_MAX_STACKS  = 255;
   localparam int DEF_MAX_SECTORS = 255;
   localparam int DEF_ANGLE_BITS  = 16;

   localparam logic [3:0] ADDR_RADIUS     = 4'd0;
   localparam logic [3:0] ADDR_STACK_STEP = 4'd4;
   localparam logic [3:0] ADDR_SECT_STEP  = 4'd8;
   localparam logic [3:0] ADDR_INV_RADIUS = 4'd12;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   localparam logic [31:0] C0 = 32'd1686629713;
   localparam logic [31:0] C1 = 32'd693598668;
   localparam logic [31:0] C2 = 32'd85569306;
   localparam logic [31:0] C3 = 32'd5026995;
   localparam logic [31:0] C4 = 32'd172272;

   // one Horner step: c - ((x2 * t) >> 30)
   function automatic logic [31:0] horner(input logic [30:0] x2, input logic [31:0] t,
                                          input logic [31:0] c);
      logic [62:0] p;
      p = {32'd0, x2} * {31'd0, t};
      return c - p[61:30];
   endfunction

endpackage

// ===== rtl/sphere_vertex_generator_core.sv =====
// ----------------------------------------------------------------------------
// Sphere vertex generator
// Usage:
//   req_ channel carries one (stack, sector) index pair per transfer.
//   rsp_ channel returns the vertex position (Q8.8) and normal (Q1.15).
//   csr_ is an APB-style port holding radius, the two step angles and the
//   inverse radius; write it only while the block is idle.
// Throughput: one vertex per clock unless the output stalls.  Pipeline:
//   13 register stages, namely the angle stage, seven sine stages (all
//   four sine/cosine lanes in parallel), two position product stages and
//   three normal/output stages.
// The pipeline advances as a whole; when rsp_tready is low and the last
//   stage is full, every stage holds and req_tready drops.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module sphere_vertex_generator_core
   import svg_pkg::*;
#(
   parameter int MAX_STACKS  = DEF_MAX_STACKS,
   parameter int MAX_SECTORS = DEF_MAX_SECTORS,
   parameter int ANGLE_BITS  = DEF_ANGLE_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // stack_index[7:0], sector_index[15:8]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[16:0] pos_y[33:17] pos_z[50:34] norm_x[66:51] norm_y[82:67]
   // norm_z[98:83], zero fill [103:99]
   output logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int AB = ANGLE_BITS;
   localparam int FB = AB - 2;
   localparam int NS = 13;

   logic [15:0] radius_ff, stack_step_ff, sect_step_ff;
   logic [23:0] inv_r_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256; stack_step_ff <= 16'd2048;
         sect_step_ff <= 16'd2048; inv_r_ff <= 24'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            ADDR_RADIUS: radius_ff <= csr_pwdata[15:0];
            ADDR_STACK_STEP: stack_step_ff <= csr_pwdata[15:0];
            ADDR_SECT_STEP: sect_step_ff <= csr_pwdata[15:0];
            ADDR_INV_RADIUS: inv_r_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         ADDR_RADIUS: csr_prdata = {16'd0, radius_ff};
         ADDR_STACK_STEP: csr_prdata = {16'd0, stack_step_ff};
         ADDR_SECT_STEP: csr_prdata = {16'd0, sect_step_ff};
         ADDR_INV_RADIUS: csr_prdata = {8'd0, inv_r_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   // global advance
   logic [NS-1:0] v_ff;
   logic adv;
   assign adv = !v_ff[NS-1] || rsp_tready;
   assign req_tready = adv;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], req_tvalid};
   end
   assign rsp_tvalid = v_ff[NS-1];

   // sin unit helpers
   function automatic logic [30:0] frac_x(input logic [AB-1:0] a);
      logic [30:0] x;
      x = 31'(a[FB-1:0]) << (30 - FB);
      return a[FB] ? ONE_Q30 - x : x;
   endfunction
   function automatic logic [30:0] sq(input logic [30:0] x);
      logic [61:0] p;
      p = 62'(x) * 62'(x);
      return p[60:30];
   endfunction
   function automatic logic [30:0] fin(input logic [30:0] x, input logic [31:0] t);
      logic [62:0] p;
      p = {32'd0, x} * {31'd0, t};
      return (p[62:30] > 33'(ONE_Q30)) ? ONE_Q30 : p[60:30];
   endfunction
   // magnitude times Q30 magnitude, rounded
   function automatic logic [16:0] mulq(input logic [16:0] m, input logic [30:0] f);
      logic [47:0] p;
      p = 48'(m) * 48'(f) + 48'h2000_0000;
      return p[46:30];
   endfunction

   // ---- stage 0: angles
   logic [7:0] st_in, se_in;
   logic [AB-1:0] a_st_ff, a_se_ff;
   always_comb begin
      st_in = (32'(req_tdata[7:0]) > 32'(MAX_STACKS)) ? 8'(MAX_STACKS) : req_tdata[7:0];
      se_in = (32'(req_tdata[15:8]) > 32'(MAX_SECTORS)) ? 8'(MAX_SECTORS)
            : req_tdata[15:8];
   end
   logic [23:0] pst, pse;
   assign pst = 24'(st_in) * 24'(stack_step_ff);
   assign pse = 24'(se_in) * 24'(sect_step_ff);

   // stage registers: 4 angles (cos/sin for stack & sector) carried together
   // lanes: 0 = cos stack, 1 = sin stack, 2 = cos sector, 3 = sin sector
   logic [1:0] q_s1_ff [4], q_s2_ff [4], q_s3_ff [4], q_s4_ff [4], q_s5_ff [4],
               q_s6_ff [4], q_s7_ff [4];
   logic [30:0] x_s1_ff [4], x_s2_ff [4], x_s3_ff [4], x_s4_ff [4], x_s5_ff [4],
                x_s6_ff [4];
   logic [30:0] x2_s2_ff [4], x2_s3_ff [4], x2_s4_ff [4], x2_s5_ff [4];
   logic [31:0] t_s3_ff [4], t_s4_ff [4], t_s5_ff [4], t_s6_ff [4];
   logic [30:0] s_s7_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         a_st_ff <= AB'(24'(1 << FB) - pst);
         a_se_ff <= AB'(pse);
      end
   end
   logic [AB-1:0] a_lane [4];
   always_comb begin
      a_lane[0] = a_st_ff + AB'(1 << FB);
      a_lane[1] = a_st_ff;
      a_lane[2] = a_se_ff + AB'(1 << FB);
      a_lane[3] = a_se_ff;
   end
   // stage 1..7 sine pipeline: fold, square, four Horner steps, final multiply
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            q_s1_ff[i] <= a_lane[i][AB-1:AB-2];
            x_s1_ff[i] <= frac_x(a_lane[i]);
            q_s2_ff[i] <= q_s1_ff[i]; x_s2_ff[i] <= x_s1_ff[i];
            x2_s2_ff[i] <= sq(x_s1_ff[i]);
            q_s3_ff[i] <= q_s2_ff[i]; x_s3_ff[i] <= x_s2_ff[i];
            x2_s3_ff[i] <= x2_s2_ff[i];
            t_s3_ff[i] <= horner(x2_s2_ff[i], C4, C3);
            q_s4_ff[i] <= q_s3_ff[i]; x_s4_ff[i] <= x_s3_ff[i];
            x2_s4_ff[i] <= x2_s3_ff[i];
            t_s4_ff[i] <= horner(x2_s3_ff[i], t_s3_ff[i], C2);
            q_s5_ff[i] <= q_s4_ff[i]; x_s5_ff[i] <= x_s4_ff[i];
            x2_s5_ff[i] <= x2_s4_ff[i];
            t_s5_ff[i] <= horner(x2_s4_ff[i], t_s4_ff[i], C1);
            q_s6_ff[i] <= q_s5_ff[i]; x_s6_ff[i] <= x_s5_ff[i];
            t_s6_ff[i] <= horner(x2_s5_ff[i], t_s5_ff[i], C0);
            q_s7_ff[i] <= q_s6_ff[i];
            s_s7_ff[i] <= fin(x_s6_ff[i], t_s6_ff[i]);
         end
      end
   end

   // ---- stage 8: xy and z magnitudes; stage 9: x, y
   logic [16:0] xy_ff, pz_m_ff;
   logic xy_n_ff, pz_n_ff;
   logic [30:0] cse_ff, sse_ff;
   logic cse_n_ff, sse_n_ff;
   logic [16:0] px_m_ff, py_m_ff, pz3_m_ff;
   logic px_n_ff, py_n_ff, pz3_n_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xy_ff <= mulq(17'(radius_ff), s_s7_ff[0]);
         xy_n_ff <= q_s7_ff[0][1] && (s_s7_ff[0] != 31'd0) && (radius_ff != 16'd0);
         pz_m_ff <= mulq(17'(radius_ff), s_s7_ff[1]);
         pz_n_ff <= q_s7_ff[1][1];
         cse_ff <= s_s7_ff[2]; cse_n_ff <= q_s7_ff[2][1];
         sse_ff <= s_s7_ff[3]; sse_n_ff <= q_s7_ff[3][1];
         px_m_ff <= mulq(xy_ff, cse_ff);
         px_n_ff <= xy_n_ff ^ cse_n_ff;
         py_m_ff <= mulq(xy_ff, sse_ff);
         py_n_ff <= xy_n_ff ^ sse_n_ff;
         pz3_m_ff <= pz_m_ff; pz3_n_ff <= pz_n_ff;
      end
   end

   // ---- stage 10: signed magnitudes; stage 11: normal products; stage 12: output
   logic [16:0] m_ff [3];
   logic n_ff [3];
   logic [41:0] np_ff [3];
   logic [16:0] m2_ff [3];
   logic n2_ff [3];
   logic [103:0] out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0] <= px_m_ff; n_ff[0] <= px_n_ff && (px_m_ff != 17'd0);
         m_ff[1] <= py_m_ff; n_ff[1] <= py_n_ff && (py_m_ff != 17'd0);
         m_ff[2] <= pz3_m_ff; n_ff[2] <= pz3_n_ff && (pz3_m_ff != 17'd0);
         for (int i = 0; i < 3; i++) begin
            np_ff[i] <= 42'(m_ff[i]) * 42'(inv_r_ff) + 42'd256;
            m2_ff[i] <= m_ff[i]; n2_ff[i] <= n_ff[i];
         end
      end
   end
   logic [16:0] pos_o [3];
   logic [15:0] nrm_o [3];
   logic [32:0] q9 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q9[i] = np_ff[i][41:9];
         pos_o[i] = n2_ff[i] ? -m2_ff[i] : m2_ff[i];
         if (n2_ff[i])
            nrm_o[i] = (q9[i] > 33'd32768) ? 16'h8000 : 16'(-q9[i][15:0]);
         else
            nrm_o[i] = (q9[i] > 33'd32767) ? 16'h7FFF : q9[i][15:0];
      end
   end
   always_ff @(posedge clock) begin
      if (adv)
         out_ff <= {5'd0, nrm_o[2], nrm_o[1], nrm_o[0], pos_o[2], pos_o[1], pos_o[0]};
   end
   assign rsp_tdata = out_ff;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere vertex generator testbench
// Drives (stack, sector) index pairs through the request stream and checks
// every vertex position and normal on the response stream against an
// in-bench fixed-point predictor, over several register settings, with
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import svg_pkg::*;

   localparam int         LATENCY        = 12;
   localparam longint     Q30_ONE        = 64'd1 << 30;
   localparam longint     Q30_HALF       = 64'd1 << 29;

   typedef struct packed {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
   } vertex_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;    // stack_index[7:0], sector_index[15:8]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // pos_x[16:0] pos_y[33:17] pos_z[50:34] norm_x[66:51] norm_y[82:67]
   // norm_z[98:83]
   logic [103:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   sphere_vertex_generator_core uut (.*);

   always #5 clock = ~clock;

   // predictor copy of the registers
   logic [15:0] radius_q88    = 16'd256;
   logic [15:0] stack_step    = 16'd2048;
   logic [15:0] sector_step   = 16'd2048;
   logic [23:0] inv_radius    = 24'd65536;

   vertex_type expected_vertices[$];
   int      error_count = 0;
   int      burst_left  = 0;
   int      gap_max     = 4;
   int      hold_left   = 0;
   bit      hold_request = 0;
   int      stall_mode  = 0;
   int      stall_timer = 0;

   function automatic longint unsigned quarter_sine(longint unsigned x);
      longint unsigned x2, t;
      x2 = (x * x) >> 30;
      t = 172272;
      t = 5026995 - ((x2 * t) >> 30);
      t = 85569306 - ((x2 * t) >> 30);
      t = 693598668 - ((x2 * t) >> 30);
      t = 1686629713 - ((x2 * t) >> 30);
      t = (x * t) >> 30;
      return (t > Q30_ONE) ? Q30_ONE : t;
   endfunction

   function automatic longint turn_sine(logic [15:0] angle);
      longint unsigned x, v;
      x = longint'(angle[13:0]) << 16;
      v = angle[14] ? quarter_sine(Q30_ONE - x) : quarter_sine(x);
      return angle[15] ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint turn_cosine(logic [15:0] angle);
      logic [15:0] shifted;
      shifted = angle + 16'd16384;
      return turn_sine(shifted);
   endfunction

   // rounds half away from zero
   function automatic longint scale_q30(longint value, longint factor);
      bit neg;
      longint unsigned a, b, m;
      neg = (value < 0) != (factor < 0);
      a = (value < 0) ? -value : value;
      b = (factor < 0) ? -factor : factor;
      m = (a * b + Q30_HALF) >> 30;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [15:0] normal_component(longint pos);
      longint unsigned a, m;
      a = (pos < 0) ? -pos : pos;
      m = (a * longint'(inv_radius) + 256) >> 9;
      if (pos < 0) return (m > 32768) ? -16'sd32768 : -16'(m);
      else return (m > 32767) ? 16'sd32767 : 16'(m);
   endfunction

   function automatic vertex_type predict_vertex(logic [7:0] stack, logic [7:0] sector);
      logic [15:0] stack_angle, sector_angle;
      longint xy, px, py, pz;
      vertex_type v;
      // indices are 8 bits, so never beyond the 255 limit
      stack_angle  = 16'd16384 - 16'(stack * stack_step);
      sector_angle = 16'(sector * sector_step);
      xy = scale_q30(longint'(radius_q88), turn_cosine(stack_angle));
      pz = scale_q30(longint'(radius_q88), turn_sine(stack_angle));
      px = scale_q30(xy, turn_cosine(sector_angle));
      py = scale_q30(xy, turn_sine(sector_angle));
      v.pos_x  = px[16:0];
      v.pos_y  = py[16:0];
      v.pos_z  = pz[16:0];
      v.norm_x = normal_component(px);
      v.norm_y = normal_component(py);
      v.norm_z = normal_component(pz);
      return v;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // predict on each request transfer
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_vertices = {expected_vertices,
                              predict_vertex(req_tdata[7:0], req_tdata[15:8])};
   end

   // check each response transfer
   always @(posedge clock) begin
      vertex_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[16:0], rsp_tdata[33:17], rsp_tdata[50:34],
                rsp_tdata[66:51], rsp_tdata[82:67], rsp_tdata[98:83]};
         if (expected_vertices.size() == 0) begin
            $display("%0t unexpected response transfer", $time);
            error_count++;
         end else begin
            want = expected_vertices.pop_front();
            if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
            if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
            if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
            if (got.norm_x !== want.norm_x)
               report_mismatch("norm_x", got.norm_x, want.norm_x);
            if (got.norm_y !== want.norm_y)
               report_mismatch("norm_y", got.norm_y, want.norm_y);
            if (got.norm_z !== want.norm_z)
               report_mismatch("norm_z", got.norm_z, want.norm_z);
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = 300;
         hold_request = 0;
      end
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_timer = $urandom_range(16, 96);
      end else begin
         stall_timer--;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic send_vertex(input logic [7:0] stack, input logic [7:0] sector);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {sector, stack};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         ADDR_RADIUS:     radius_q88  = data[15:0];
         ADDR_STACK_STEP: stack_step  = data[15:0];
         ADDR_SECT_STEP:  sector_step = data[15:0];
         ADDR_INV_RADIUS: inv_radius  = data[23:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [15:0] r, input logic [15:0] st,
                              input logic [15:0] se, input logic [23:0] inv);
      drain_pipeline();
      csr_write(ADDR_RADIUS, {16'd0, r});
      csr_write(ADDR_STACK_STEP, {16'd0, st});
      csr_write(ADDR_SECT_STEP, {16'd0, se});
      csr_write(ADDR_INV_RADIUS, {8'd0, inv});
   endtask

   task automatic send_corners();
      send_vertex(8'd0, 8'd0);
      send_vertex(8'd255, 8'd255);
      send_vertex(8'd0, 8'd255);
      send_vertex(8'd255, 8'd0);
      send_vertex(8'd8, 8'd8);
      send_vertex(8'd16, 8'd24);
   endtask

   task automatic test_directed();
      // reset registers: unit sphere, 1/32 turn steps, includes poles
      send_corners();
      // largest radius and inverse radius: normals saturate
      load_config(16'hFFFF, 16'd4096, 16'd8192, 24'hFFFFFF);
      send_corners();
      // all-ones steps wrap, zero radius and zero steps
      load_config(16'd0, 16'hFFFF, 16'hFFFF, 24'd0);
      send_corners();
      load_config(16'd1000, 16'd0, 16'd0, 24'd16777);
      send_corners();
   endtask

   task automatic test_random_settings();
      logic [15:0] r, st, se;
      logic [23:0] inv;
      for (int phase = 0; phase < 6; phase++) begin
         r   = (phase == 0) ? 16'hFFFF : 16'($urandom);
         st  = (phase == 1) ? 16'hFFFF : 16'($urandom);
         se  = (phase == 1) ? 16'd0 : 16'($urandom);
         inv = (phase == 2) ? 24'hFFFFFF :
               (phase == 3) ? 24'd0 : 24'($urandom);
         load_config(r, st, se, inv);
         gap_max = (phase % 2) ? 0 : 6;
         for (int i = 0; i < 130; i++)
            send_vertex(8'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_backpressure();
      load_config(16'd256, 16'd1024, 16'd3000, 24'd65536);
      gap_max = 0;
      burst_left = 0;
      hold_request = 1;
      for (int i = 0; i < 60; i++)
         send_vertex(8'($urandom), 8'($urandom));
      // sender pauses until every expected vertex has come back
      drain_pipeline();
      gap_max = 3;
      for (int i = 0; i < 40; i++)
         send_vertex(8'($urandom), 8'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      test_backpressure();
      drain_pipeline();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
